// ===== sv/ipv4_range_membership_table_assert.svh =====
`ifndef IPV4_RANGE_MEMBERSHIP_TABLE_ASSERT_SVH
`define IPV4_RANGE_MEMBERSHIP_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPRMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("range table check failed");

// next-cycle implication, checked outside reset
`define IPRMT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("range table check failed");

`endif

// ===== sv/iprmt_pkg.sv =====
package iprmt_pkg;

  typedef enum logic [1:0] {
    REQ_PREFIX = 2'd0,
    REQ_RANGE  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [5:0]  PREFIX_MAX    = 6'd32;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic        hit;
  } tok_t;

endpackage

// ===== sv/ipv4_range_membership_table.sv =====
// Channel  Direction  Signals                                           Handshake
// request  in         req_type_i address_i range_end_i prefix_length_i  start & !busy
// result   out        status_o matched_o                                done_o strobe
// config   in         cfg_data_i                                        cfg_valid_i & cfg_ready_o
//
// Inserts and clears: the result strobes in the cycle after the transaction.
// Lookups: the key walks the row of MAX_RANGES cells, one cell per cycle, and the
// result strobes once the key has left the last cell; busy is high until then.
// Reset empties the table and clears strict alignment; no clearing pass.
// The result strobe lasts one cycle and cannot be held off.
module ipv4_range_membership_table #(
  parameter int MAX_RANGES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] address_i,
  input  logic [31:0] range_end_i,
  input  logic [5:0]  prefix_length_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        matched_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int CntW = $clog2(MAX_RANGES + 1);

  iprmt_pkg::tok_t tok   [MAX_RANGES+1];
  logic [CntW-1:0] rem   [MAX_RANGES+1];
  logic [MAX_RANGES-1:0] wr_en;

  logic              accept;
  logic              strict_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   count_d;
  logic              busy_q;
  logic              busy_d;
  logic              done_q;
  logic              done_d;
  logic [1:0]        status_q;
  logic [1:0]        status_d;
  logic              matched_q;
  logic              matched_d;
  logic [1:0]        ins_status;
  logic              store;
  logic [31:0]       host;
  logic [31:0]       new_low;
  logic [31:0]       new_high;
  logic              full;
  logic              is_lookup;

  assign accept      = start && !busy_q;
  assign is_lookup   = (req_type_i == iprmt_pkg::REQ_LOOKUP);
  assign full        = (count_q == CntW'(MAX_RANGES));
  assign host        = iprmt_pkg::ADDR_ALL_ONES >> prefix_length_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ins_status = iprmt_pkg::ST_OK;
    store      = 1'b0;
    new_low    = address_i;
    new_high   = range_end_i;
    count_d    = count_q;
    case (iprmt_pkg::req_e'(req_type_i))
      iprmt_pkg::REQ_PREFIX: begin
        new_low  = address_i & ~host;
        new_high = (address_i & ~host) | host;
        if (prefix_length_i > iprmt_pkg::PREFIX_MAX) begin
          ins_status = iprmt_pkg::ST_INVALID;
        end else if (strict_q && ((address_i & host) != '0)) begin
          ins_status = iprmt_pkg::ST_INVALID;
        end else if (full) begin
          ins_status = iprmt_pkg::ST_FULL;
        end else begin
          store = 1'b1;
        end
      end
      iprmt_pkg::REQ_RANGE: begin
        if (range_end_i < address_i) begin
          ins_status = iprmt_pkg::ST_INVALID;
        end else if (full) begin
          ins_status = iprmt_pkg::ST_FULL;
        end else begin
          store = 1'b1;
        end
      end
      iprmt_pkg::REQ_LOOKUP: begin
      end
      iprmt_pkg::REQ_CLEAR: begin
        if (accept) begin
          count_d = '0;
        end
      end
      default: begin
      end
    endcase
    if (accept && store) begin
      count_d = count_q + CntW'(1);
    end
  end

  assign tok[0] = '{valid: accept && is_lookup, key: address_i, hit: 1'b0};
  assign rem[0] = count_q;

  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
    assign wr_en[k] = accept && store && (count_q == CntW'(k));

    iprmt_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en[k]),
      .wr_low_i  (new_low),
      .wr_high_i (new_high),
      .tok_i     (tok[k]),
      .rem_i     (rem[k]),
      .tok_o     (tok[k+1]),
      .rem_o     (rem[k+1])
    );
  end

  always_comb begin
    done_d    = (accept && !is_lookup) || tok[MAX_RANGES].valid;
    status_d  = tok[MAX_RANGES].valid ? iprmt_pkg::ST_OK : ins_status;
    matched_d = tok[MAX_RANGES].valid & tok[MAX_RANGES].hit;
    busy_d    = busy_q;
    if (accept && is_lookup) begin
      busy_d = 1'b1;
    end else if (tok[MAX_RANGES].valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      strict_q <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        strict_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      status_q  <= status_d;
      matched_q <= matched_d;
    end
  end

  assign busy      = busy_q;
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign matched_o = matched_q;

endmodule

// ===== sv/iprmt_cell.sv =====
module iprmt_cell #(
  parameter int CntW = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [31:0]         wr_low_i,
  input  logic [31:0]         wr_high_i,
  input  iprmt_pkg::tok_t     tok_i,
  input  logic [CntW-1:0]     rem_i,
  output iprmt_pkg::tok_t     tok_o,
  output logic [CntW-1:0]     rem_o
);

  logic [31:0]     low_q;
  logic [31:0]     high_q;
  iprmt_pkg::tok_t tok_q;
  iprmt_pkg::tok_t tok_d;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] rem_d;
  logic            live;
  logic            inside_rng;

  assign live       = (rem_i != '0);
  assign inside_rng = (tok_i.key >= low_q) && (tok_i.key <= high_q);

  always_comb begin
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | (live & inside_rng);
    rem_d     = live ? (rem_i - CntW'(1)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      low_q  <= wr_low_i;
      high_q <= wr_high_i;
    end
  end

  // advance the key through the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign tok_o = tok_q;
  assign rem_o = rem_q;

endmodule

// ===== sv/iprmt_checker.sv =====
`include "ipv4_range_membership_table_assert.svh"

module iprmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  req_type_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic        matched_o
);

  `IPRMT_ASSERT_NXT(a_cmd_done, start && !busy && (req_type_i != iprmt_pkg::REQ_LOOKUP), done_o)
  `IPRMT_ASSERT_NXT(a_lookup_busy, start && !busy && (req_type_i == iprmt_pkg::REQ_LOOKUP), busy)
  `IPRMT_ASSERT_IMP(a_busy_quiet, busy, !done_o)
  `IPRMT_ASSERT_IMP(a_match_ok, done_o && matched_o, status_o == iprmt_pkg::ST_OK)
  `IPRMT_ASSERT_IMP(a_status_code, done_o, status_o <= iprmt_pkg::ST_FULL)

endmodule

bind ipv4_range_membership_table iprmt_checker u_iprmt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .req_type_i (req_type_i),
  .done_o     (done_o),
  .status_o   (status_o),
  .matched_o  (matched_o)
);
